FILE: rtl/core/pgpl_pkg.sv
package pgpl_pkg;

  localparam int ColorW = 15;
  localparam int FracW  = 28;

  localparam logic [ColorW-1:0] FULL_SCALE  = 15'h7fff;
  localparam logic [15:0]       GAMMA_RESET = 16'd4096;

  // log2: one normalize stage, then one squaring per fraction bit
  localparam int LOG_STEPS  = 28;
  localparam int LOG_LAT    = LOG_STEPS + 1;
  // exp2: one square root per fraction bit, one root digit per stage
  localparam int EXP_STEPS  = 28;
  localparam int SQRT_STEPS = 32;
  localparam int EXP_LAT    = EXP_STEPS * SQRT_STEPS;
  // log, difference, exponent product, exp, scale multiply, round/clamp
  localparam int CORE_LAT   = LOG_LAT + 2 + EXP_LAT + 2;

  typedef struct packed {
    logic              force_en;
    logic [ColorW-1:0] force_val;
    logic [3:0]        shift_n;
  } side_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic        frame_end;
  } meta_t;

  // elaboration-time log2 in Q.28, same procedure as the pipeline
  function automatic logic [31:0] log2_q28(input logic [15:0] x);
    logic [63:0] m;
    logic [63:0] sq;
    logic [27:0] frac;
    logic [3:0]  e;
    e    = '0;
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) e = 4'(i);
    end
    m = 64'(x) << (30 - e);
    for (int k = 0; k < LOG_STEPS; k++) begin
      sq = (m * m) >> 30;
      if (sq[31]) begin
        frac = {frac[26:0], 1'b1};
        m    = sq >> 1;
      end else begin
        frac = {frac[26:0], 1'b0};
        m    = sq;
      end
    end
    return {e, frac};
  endfunction

  localparam logic [31:0] LOG2_FULL_SCALE = log2_q28(16'(FULL_SCALE));

endpackage

FILE: rtl/core/pgpl_if.sv
interface pgpl_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  logic        frame_end_in;
  modport source(output valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
                 input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
               output ready);
endinterface

interface pgpl_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] red_out;
  logic [14:0] green_out;
  logic [14:0] blue_out;
  logic [15:0] alpha_out;
  logic        frame_end_out;
  modport source(output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
               output ready);
endinterface

interface pgpl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: rtl/core/pgpl_log2.sv
module pgpl_log2 (
  input  logic            clk,
  input  logic            ce,
  input  logic [14:0]     x,
  input  pgpl_pkg::side_t side_i,
  output logic [31:0]     log_o,
  output pgpl_pkg::side_t side_o
);
  import pgpl_pkg::*;

  logic [30:0]      m    [LOG_LAT];
  logic [FracW-1:0] frac [LOG_LAT];
  logic [3:0]       expo [LOG_LAT];
  side_t            side [LOG_LAT];

  logic [3:0]  e_top;
  logic [45:0] m_wide;

  always_comb begin
    e_top = '0;
    for (int i = 0; i < 15; i++) begin
      if (x[i]) e_top = 4'(i);
    end
    m_wide = 46'(x) << (5'd30 - 5'(e_top));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m[0]    <= m_wide[30:0];
      frac[0] <= '0;
      expo[0] <= e_top;
      side[0] <= side_i;
    end
  end

  for (genvar k = 1; k < LOG_LAT; k++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sq;
    assign prod = 62'(m[k-1]) * 62'(m[k-1]);
    assign sq   = prod[61:30];
    always_ff @(posedge clk) begin
      if (ce) begin
        m[k]    <= sq[31] ? sq[31:1] : sq[30:0];
        frac[k] <= {frac[k-1][FracW-2:0], sq[31]};
        expo[k] <= expo[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign log_o  = {expo[LOG_LAT-1], frac[LOG_LAT-1]};
  assign side_o = side[LOG_LAT-1];

endmodule

FILE: rtl/core/pgpl_exp2.sv
module pgpl_exp2 (
  input  logic            clk,
  input  logic            ce,
  input  logic [27:0]     f_i,
  input  pgpl_pkg::side_t side_i,
  output logic [31:0]     v_o,
  output pgpl_pkg::side_t side_o
);
  import pgpl_pkg::*;

  logic [63:0]      rem  [EXP_LAT];
  logic [63:0]      root [EXP_LAT];
  logic [FracW-1:0] fb   [EXP_LAT];
  side_t            side [EXP_LAT];

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_dig
      localparam int          S   = k * SQRT_STEPS + j;
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [63:0]      x_in;
      logic [63:0]      r_in;
      logic [63:0]      trial;
      logic [FracW-1:0] f_in;
      side_t            s_in;

      if (j == 0) begin : g_head
        logic [63:0] v_cur;
        if (k == 0) begin : g_first
          assign v_cur = 64'h8000_0000;
          assign f_in  = f_i;
          assign s_in  = side_i;
        end else begin : g_next
          assign v_cur = root[S-1];
          assign f_in  = fb[S-1];
          assign s_in  = side[S-1];
        end
        // halve on a set fraction bit, then take sqrt(v * 2^31)
        assign x_in = (f_in[k] ? (v_cur >> 1) : v_cur) << 31;
        assign r_in = '0;
      end else begin : g_body
        assign x_in = rem[S-1];
        assign r_in = root[S-1];
        assign f_in = fb[S-1];
        assign s_in = side[S-1];
      end

      assign trial = r_in + BIT;

      always_ff @(posedge clk) begin
        if (ce) begin
          if (x_in >= trial) begin
            rem[S]  <= x_in - trial;
            root[S] <= (r_in >> 1) + BIT;
          end else begin
            rem[S]  <= x_in;
            root[S] <= r_in >> 1;
          end
          fb[S]   <= f_in;
          side[S] <= s_in;
        end
      end
    end
  end

  assign v_o    = root[EXP_LAT-1][31:0];
  assign side_o = side[EXP_LAT-1];

endmodule

FILE: rtl/core/pgpl_channel.sv
module pgpl_channel (
  input  logic        clk,
  input  logic        ce,
  input  logic [15:0] c,
  input  logic [15:0] gamma,
  output logic [14:0] y_o
);
  import pgpl_pkg::*;

  side_t       side_in;
  logic [31:0] lc;
  side_t       side_log;

  always_comb begin
    side_in.force_en  = (c >= 16'(FULL_SCALE)) || (c == '0) || (gamma == '0);
    side_in.force_val = (c >= 16'(FULL_SCALE)) ? FULL_SCALE : c[14:0];
    side_in.shift_n   = '0;
  end

  pgpl_log2 u_log (
    .clk    (clk),
    .ce     (ce),
    .x      (c[14:0]),
    .side_i (side_in),
    .log_o  (lc),
    .side_o (side_log)
  );

  // distance below full scale
  logic [31:0] d;
  side_t       side_d;
  always_ff @(posedge clk) begin
    if (ce) begin
      d      <= (LOG2_FULL_SCALE > lc) ? (LOG2_FULL_SCALE - lc) : '0;
      side_d <= side_log;
    end
  end

  // scale by gamma, round Q.12 away
  logic [47:0] p_full;
  logic [35:0] p;
  logic [27:0] f_p;
  side_t       side_p;
  side_t       side_p_next;
  assign p_full = 48'(d) * 48'(gamma) + 48'd2048;
  assign p      = p_full[47:12];

  always_comb begin
    side_p_next         = side_d;
    side_p_next.shift_n = p[31:28];
    if (!side_d.force_en && (p[35:28] >= 8'd16)) begin
      side_p_next.force_en  = 1'b1;
      side_p_next.force_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_p    <= p[27:0];
      side_p <= side_p_next;
    end
  end

  logic [31:0] v;
  side_t       side_e;

  pgpl_exp2 u_exp (
    .clk    (clk),
    .ce     (ce),
    .f_i    (f_p),
    .side_i (side_p),
    .v_o    (v),
    .side_o (side_e)
  );

  logic [46:0] prod;
  side_t       side_y;
  always_ff @(posedge clk) begin
    if (ce) begin
      prod   <= 47'(FULL_SCALE) * 47'(v);
      side_y <= side_e;
    end
  end

  logic [47:0] sum;
  logic [47:0] shifted;
  logic [14:0] y_val;
  always_comb begin
    sum     = 48'(prod) + (48'd1 << (6'd21 + 6'(side_y.shift_n)));
    shifted = sum >> (6'd31 + 6'(side_y.shift_n));
    y_val   = (shifted > 48'(FULL_SCALE)) ? FULL_SCALE : shifted[14:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      y_o <= side_y.force_en ? side_y.force_val : y_val;
    end
  end

endmodule

FILE: rtl/core/pixel_gamma_power_law_core.sv
// Power-law gamma correction, one RGBA pixel per beat.
// pix_in carries red, green, blue (full scale 32767, larger values saturate),
// alpha and an end-of-frame mark; pix_out carries the corrected 15-bit colors
// with alpha and the mark copied through. cfg writes the Q4.12 exponent;
// zero selects bypass. Write it only while no pixel is in flight.
// Each color runs log2 (28 squaring stages), a gamma multiply, exp2 (28
// square roots, one root digit per stage), a scale multiply and a round stage.
// Throughput: one pixel per cycle unless pix_out stalls; the stage count is
// set by the digit-serial square roots in exp2.
// Reset clears all valid bits and loads gamma 1.0 (4096); data is not cleared.
// A stalled receiver freezes the whole pipeline: pix_in.ready drops in the
// same cycle and the held output beat stays stable until it is taken.
module pixel_gamma_power_law_core (
  input logic         clk,
  input logic         rst,
  pgpl_pix_if.sink    pix_in,
  pgpl_res_if.source  pix_out,
  pgpl_cfg_if.sink    cfg
);
  import pgpl_pkg::*;

  logic [15:0] gamma;
  logic        ce;
  logic        vld  [CORE_LAT];
  meta_t       meta [CORE_LAT];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg.valid) begin
      gamma <= cfg.data;
    end
  end

  assign ce           = !vld[CORE_LAT-1] || pix_out.ready;
  assign pix_in.ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      meta[0] <= '{alpha: pix_in.alpha_in, frame_end: pix_in.frame_end_in};
    end
  end

  for (genvar i = 1; i < CORE_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (ce) begin
        vld[i] <= vld[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        meta[i] <= meta[i-1];
      end
    end
  end

  pgpl_channel u_red (
    .clk(clk), .ce(ce), .c(pix_in.red_in), .gamma(gamma), .y_o(pix_out.red_out)
  );
  pgpl_channel u_green (
    .clk(clk), .ce(ce), .c(pix_in.green_in), .gamma(gamma), .y_o(pix_out.green_out)
  );
  pgpl_channel u_blue (
    .clk(clk), .ce(ce), .c(pix_in.blue_in), .gamma(gamma), .y_o(pix_out.blue_out)
  );

  assign pix_out.valid         = vld[CORE_LAT-1];
  assign pix_out.alpha_out     = meta[CORE_LAT-1].alpha;
  assign pix_out.frame_end_out = meta[CORE_LAT-1].frame_end;

endmodule

FILE: rtl/core/pgpl_checker.sv
module pgpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_red
);

  // pipeline advances exactly when the output register can move
  a_ready_tracks_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red))
    else $error("output beat changed while stalled");

endmodule

bind pixel_gamma_power_law_core pgpl_checker u_pgpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_red   (pix_out.red_out)
);

FILE: dv/pgpl_gamma_checker.sv
`timescale 1ns / 100ps

module pgpl_gamma_checker (
  input  logic clk,
  input  logic rst,
  pgpl_pix_if  pix_in,
  pgpl_res_if  pix_out,
  pgpl_cfg_if  cfg,
  output int   error_count,
  output int   pending_count
);
  import pgpl_pkg::*;

  typedef struct packed {
    logic [14:0] red;
    logic [14:0] green;
    logic [14:0] blue;
    logic [15:0] alpha;
    logic        frame_end;
  } pixel_t;

  localparam logic [63:0] FS = 64'd32767;

  logic [15:0] gamma_reg;
  pixel_t      expected_pixels[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    e    = 0;
    frac = 0;
    while (e < 15 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int k = 0; k < 28; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m    = m >> 1;
      end
    end
    return (64'(e) << 28) | frac;
  endfunction

  function automatic logic [14:0] corrected_color(input logic [15:0] c, input logic [15:0] g);
    logic [63:0] lf, lc, d, p, n, f, v, y;
    if (64'(c) >= FS) return 15'(FS);
    if (c == 0) return 0;
    if (g == 0) return 15'(c);
    lf = log2_fixed(FS);
    lc = log2_fixed(64'(c));
    d  = (lf > lc) ? lf - lc : 0;
    p  = (d * 64'(g) + 64'd2048) >> 12;
    n  = p >> 28;
    if (n >= 16) return 0;
    f = p & ((64'd1 << 28) - 1);
    v = 64'd1 << 31;
    for (int k = 0; k < 28; k++) begin
      if (f[k]) v = v >> 1;
      v = int_sqrt(v << 31);
    end
    y = (FS * v + (64'd1 << (21 + n))) >> (31 + n);
    if (y > FS) y = FS;
    return 15'(y);
  endfunction

  assign pending_count = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      gamma_reg <= GAMMA_RESET;
      error_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) gamma_reg <= cfg.data;
      if (pix_in.valid && pix_in.ready) begin
        exp_px.red       = corrected_color(pix_in.red_in, gamma_reg);
        exp_px.green     = corrected_color(pix_in.green_in, gamma_reg);
        exp_px.blue      = corrected_color(pix_in.blue_in, gamma_reg);
        exp_px.alpha     = pix_in.alpha_in;
        exp_px.frame_end = pix_in.frame_end_in;
        expected_pixels.push_back(exp_px);
      end
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("output beat with no pixel pending");
          error_count <= error_count + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px.red != pix_out.red_out ||
              exp_px.green != pix_out.green_out ||
              exp_px.blue != pix_out.blue_out ||
              exp_px.alpha != pix_out.alpha_out ||
              exp_px.frame_end != pix_out.frame_end_out) begin
            error_count <= error_count + 1;
            if (exp_px.red != pix_out.red_out)
              $error("red_out: expected %0d, got %0d", exp_px.red, pix_out.red_out);
            if (exp_px.green != pix_out.green_out)
              $error("green_out: expected %0d, got %0d", exp_px.green, pix_out.green_out);
            if (exp_px.blue != pix_out.blue_out)
              $error("blue_out: expected %0d, got %0d", exp_px.blue, pix_out.blue_out);
            if (exp_px.alpha != pix_out.alpha_out)
              $error("alpha_out: expected %0d, got %0d", exp_px.alpha, pix_out.alpha_out);
            if (exp_px.frame_end != pix_out.frame_end_out)
              $error("frame_end_out: expected %0d, got %0d", exp_px.frame_end,
                     pix_out.frame_end_out);
          end
        end
      end
    end
  end
endmodule

FILE: dv/pixel_gamma_power_law_core_test.sv
`timescale 1ns / 100ps

module pixel_gamma_power_law_core_test;
  import pgpl_pkg::*;

  localparam int DRAIN_CYCLES = 1000;

  logic clk = 0;
  logic rst = 1;
  int   error_count;
  int   pending_count;

  pgpl_pix_if pix_in();
  pgpl_res_if pix_out();
  pgpl_cfg_if cfg();

  pixel_gamma_power_law_core DUT (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source), .cfg(cfg.sink)
  );

  pgpl_gamma_checker checker_i (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out), .cfg(cfg),
    .error_count(error_count), .pending_count(pending_count)
  );

  always #6 clk = ~clk;

  initial begin
    pix_in.valid = 0;
    pix_in.red_in = 0;
    pix_in.green_in = 0;
    pix_in.blue_in = 0;
    pix_in.alpha_in = 0;
    pix_in.frame_end_in = 0;
    pix_out.ready = 0;
    cfg.valid = 0;
    cfg.data = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls, mostly short with a few long; some phases never stall
  initial begin
    int stall_mode;
    @(posedge clk);
    forever begin
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 400)) begin
        pix_out.ready <= 1'b1;
        @(posedge clk);
        if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
          repeat (gap_len()) begin
            pix_out.ready <= 1'b0;
            @(posedge clk);
          end
        end
      end
    end
  end

  function automatic logic [15:0] random_color();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 8));
      2: return 16'($urandom_range(32760, 32775));
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] r, g, b, a, input logic fe);
    repeat (gap_len()) begin
      pix_in.valid <= 0;
      @(posedge clk);
    end
    pix_in.valid <= 1;
    pix_in.red_in <= r;
    pix_in.green_in <= g;
    pix_in.blue_in <= b;
    pix_in.alpha_in <= a;
    pix_in.frame_end_in <= fe;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  task automatic write_gamma(input logic [15:0] value);
    pix_in.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg.valid <= 1;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  task automatic random_pixels(input int count);
    repeat (count)
      send_pixel(random_color(), random_color(), random_color(),
                 16'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset gamma 1.0: extremes, zero, saturation
    send_pixel(16'd0, 16'd32767, 16'd65535, 16'd0, 1'b0);
    send_pixel(16'd1, 16'd32766, 16'd32768, 16'hffff, 1'b1);
    send_pixel(16'h5555, 16'haaaa, 16'd16384, 16'h5555, 1'b0);
    write_gamma(16'd0);  // bypass
    send_pixel(16'd0, 16'd1, 16'hffff, 16'haaaa, 1'b1);
    send_pixel(16'd32766, 16'd12345, 16'd32767, 16'd7, 1'b0);
    write_gamma(16'hffff);
    send_pixel(16'd1, 16'd16384, 16'd32766, 16'd1, 1'b0);
    send_pixel(16'd32000, 16'd30000, 16'd2, 16'd3, 1'b1);
    write_gamma(16'd1);
    send_pixel(16'd1, 16'd100, 16'd32766, 16'd9, 1'b0);
    write_gamma(16'd9011);  // about 2.2
    send_pixel(16'd1, 16'd16384, 16'd32766, 16'd0, 1'b1);
    random_pixels(100);
    write_gamma(16'd1862);  // about 1/2.2
    random_pixels(100);
    write_gamma(16'($urandom_range(1, 65535)));
    random_pixels(100);
    write_gamma(16'($urandom_range(0, 65535)));
    random_pixels(100);
    pix_in.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("FAIL");
    $finish;
  end
endmodule
